>>> rtl/core/pwo_pkg.sv
// ----------------------------------------------------------------------------
// pwo_pkg: shared definitions for the polyphonic wavetable oscillator
// Operation codes, field widths, default sizes and accumulator control types.
// ----------------------------------------------------------------------------
`default_nettype none

package pwo_pkg;

  // Default sizes; the top level takes these as parameter defaults.
  localparam int TABLE_SIZE_DEF  = 256;
  localparam int VOICE_COUNT_DEF = 128;
  localparam int PHASE_BITS_DEF  = 24;

  // Input item field widths.
  localparam int OP_W    = 3;
  localparam int NOTE_W  = 7;
  localparam int TIDX_W  = 8;
  localparam int TBYTE_W = 8;
  localparam int STEP_W  = 24;

  // Bus widths (fields packed from bit 0, padded to whole bytes).
  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 24;

  // Sample, gain and mix widths.
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int SCALED_W = 17;
  localparam int SUM_W    = 24;
  localparam int MIX_W    = 21;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd13107;

  localparam logic signed [SUM_W-1:0] SUM_HI = 24'sd1048575;
  localparam logic signed [SUM_W-1:0] SUM_LO = -24'sd1048576;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_TICK        = 3'd0;
  localparam logic [OP_W-1:0] OP_NOTE_ON     = 3'd1;
  localparam logic [OP_W-1:0] OP_NOTE_OFF    = 3'd2;
  localparam logic [OP_W-1:0] OP_TABLE_WRITE = 3'd3;
  localparam logic [OP_W-1:0] OP_STEP_WRITE  = 3'd4;

  // Control into the scale-and-accumulate unit.
  typedef struct packed {
    logic clear;
    logic valid;
  } acc_ctrl_t;

  // Status out of the scale-and-accumulate unit.
  typedef struct packed {
    logic busy;
  } acc_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/pwo_scale_acc.sv
// ----------------------------------------------------------------------------
// pwo_scale_acc: gain scaling and mix accumulation
// Multiplies each table sample by the gain, floors to Q.15 and sums.
// ----------------------------------------------------------------------------
`default_nettype none

module pwo_scale_acc (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire pwo_pkg::acc_ctrl_t                   ctrl,
  input  wire logic        [pwo_pkg::SAMPLE_W-1:0]  sample,
  input  wire logic        [pwo_pkg::GAIN_W-1:0]    gain,
  output logic signed      [pwo_pkg::SUM_W-1:0]     sum,
  output pwo_pkg::acc_stat_t                        stat
);

  localparam int PROD_W = pwo_pkg::SAMPLE_W + pwo_pkg::GAIN_W + 1;

  logic signed [PROD_W-1:0]            prod;
  logic                                prod_v;
  logic signed [pwo_pkg::SCALED_W-1:0] scaled;

  // Dropping the low 16 bits of a two's complement product floors it.
  assign scaled = prod[PROD_W-1 -: pwo_pkg::SCALED_W];

  always_ff @(posedge clk) begin
    prod <= $signed(sample) * $signed({1'b0, gain});
    if (rst) begin
      prod_v <= 1'b0;
      sum    <= '0;
    end else begin
      prod_v <= ctrl.valid;
      if (ctrl.clear) begin
        sum <= '0;
      end else if (prod_v) begin
        sum <= sum + {{(pwo_pkg::SUM_W - pwo_pkg::SCALED_W){scaled[pwo_pkg::SCALED_W-1]}},
                      scaled};
      end
    end
  end

  assign stat.busy = prod_v;

endmodule

`default_nettype wire

>>> rtl/core/polyphonic_wavetable_oscillator_top.sv
// ----------------------------------------------------------------------------
// polyphonic_wavetable_oscillator_top: multi-voice wavetable oscillator
// Voice state and wavetable held in synchronous RAMs, one voice per cycle.
// ----------------------------------------------------------------------------
// The block takes one item at a time on the slave stream. Note on, note off
// and step write items with a note below VOICE_COUNT each take a read and a
// write back of the voice RAM; a table write is done at its transfer and the
// block stays idle. A tick walks all VOICE_COUNT voices through the voice
// RAM, one read per cycle, then drains the pipeline before its mix sample is
// loaded, and the next item is taken only once that sample is loaded. The
// result sits in an output register, so the next item is taken while the
// sample waits for its transfer; a tick finishing while the previous sample
// is still unsent waits for it. After reset a clearing pass zeroes the voice
// RAM and loads a rising ramp into the wavetable; no item is taken during it,
// while gain writes are taken at any time. Each active voice advances its
// phase by its step modulo 2^PHASE_BITS, reads the table at
// floor(phase * TABLE_SIZE / 2^PHASE_BITS), is scaled by the gain with
// flooring to Q.15, and the sum of all active voices is clamped to 21 signed
// bits. A step that was never written for a voice reads as whatever the RAM
// holds after the clearing pass (zero).
// ----------------------------------------------------------------------------
`default_nettype none

module polyphonic_wavetable_oscillator_top #(
  parameter int TABLE_SIZE  = pwo_pkg::TABLE_SIZE_DEF,
  parameter int VOICE_COUNT = pwo_pkg::VOICE_COUNT_DEF,
  parameter int PHASE_BITS  = pwo_pkg::PHASE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Gain register write port.
  input  wire logic                            cfg_we,
  input  wire logic [pwo_pkg::GAIN_W-1:0]      cfg_data,
  // Input items. s_tdata from bit 0: op[2:0], note[9:3], table_index[17:10],
  // table_byte[25:18], phase_step[49:26], zeros[55:50].
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [pwo_pkg::S_TDATA_W-1:0]   s_tdata,
  // Mix samples. m_tdata from bit 0: mix_sample[20:0], zeros[23:21].
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [pwo_pkg::M_TDATA_W-1:0]        m_tdata
);

  // --------------------------------------------------------------------------
  // Derived sizes
  // --------------------------------------------------------------------------
  localparam int VA_W    = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int TI_W    = $clog2(TABLE_SIZE);
  localparam int CLR_LEN = (TABLE_SIZE > VOICE_COUNT) ? TABLE_SIZE : VOICE_COUNT;
  localparam int CLR_W   = $clog2(CLR_LEN + 1);
  localparam int IDX_PW  = PHASE_BITS + TI_W + 1;
  // Ramp generator: entry i = floor(i * 65536 / TABLE_SIZE) - 32768, built
  // incrementally as a quotient and remainder.
  localparam int Q_INC   = 65536 / TABLE_SIZE;
  localparam int R_INC   = 65536 % TABLE_SIZE;
  localparam int Q_W     = 17;
  localparam int R_W     = TI_W + 1;
  // Cycles between the last voice read of a tick and a settled mix sum.
  localparam int DRAIN_LEN = 5;
  localparam int DRAIN_W   = $clog2(DRAIN_LEN);

  typedef struct packed {
    logic                  active;
    logic [PHASE_BITS-1:0] step;
    logic [PHASE_BITS-1:0] phase;
  } voice_t;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_VRMW  = 6'b000100,
    ST_TICK  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  // --------------------------------------------------------------------------
  // Input field unpacking
  // --------------------------------------------------------------------------
  logic [pwo_pkg::OP_W-1:0]    in_op;
  logic [pwo_pkg::NOTE_W-1:0]  in_note;
  logic [pwo_pkg::TIDX_W-1:0]  in_tidx;
  logic [pwo_pkg::TBYTE_W-1:0] in_tbyte;
  logic [pwo_pkg::STEP_W-1:0]  in_step;

  assign in_op    = s_tdata[2:0];
  assign in_note  = s_tdata[9:3];
  assign in_tidx  = s_tdata[17:10];
  assign in_tbyte = s_tdata[25:18];
  assign in_step  = s_tdata[49:26];

  logic                                  note_ok;
  logic [VA_W-1:0]                       note_addr;
  logic [TI_W+pwo_pkg::TIDX_W-1:0]       tidx_ext;
  logic                                  tidx_ok;
  logic [PHASE_BITS+pwo_pkg::STEP_W-1:0] step_ext;
  logic [PHASE_BITS-1:0]                 step_masked;

  assign note_ok     = {1'b0, in_note} < (pwo_pkg::NOTE_W + 1)'(VOICE_COUNT);
  assign note_addr   = in_note[VA_W-1:0];
  assign tidx_ext    = {{TI_W{1'b0}}, in_tidx};
  assign tidx_ok     = tidx_ext < (TI_W + pwo_pkg::TIDX_W)'(TABLE_SIZE);
  // Zero-extend then cut, so the step is masked to PHASE_BITS at any width.
  assign step_ext    = {{PHASE_BITS{1'b0}}, in_step};
  assign step_masked = step_ext[PHASE_BITS-1:0];

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  state_t                          state;
  logic   [CLR_W-1:0]              clr_cnt;
  logic   [Q_W-1:0]                ramp_q;
  logic   [R_W-1:0]                ramp_r;
  logic   [R_W-1:0]                ramp_r_sum;
  logic   [VA_W-1:0]               iss;
  logic   [DRAIN_W-1:0]            drain_cnt;
  logic   [pwo_pkg::GAIN_W-1:0]    gain;
  logic   [pwo_pkg::OP_W-1:0]      op_r;
  logic   [VA_W-1:0]               note_r;
  logic   [PHASE_BITS-1:0]         step_r;
  logic                            in_xfer;
  logic                            tick_start;

  assign s_tready   = (state == ST_IDLE);
  assign in_xfer    = s_tvalid && s_tready;
  assign tick_start = in_xfer && (in_op == pwo_pkg::OP_TICK);
  assign ramp_r_sum = ramp_r + R_W'(R_INC);

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  voice_t                        vmem [VOICE_COUNT];
  logic   [pwo_pkg::SAMPLE_W-1:0] tmem [TABLE_SIZE];

  voice_t                         vq;
  logic   [VA_W-1:0]              rd_addr;
  logic                           vwe;
  logic   [VA_W-1:0]              vwaddr;
  voice_t                         vwdata;

  logic                           twe;
  logic   [TI_W-1:0]              twaddr;
  logic   [pwo_pkg::SAMPLE_W-1:0] twdata;
  logic   [pwo_pkg::SAMPLE_W-1:0] tq;

  // --------------------------------------------------------------------------
  // Tick pipeline
  // --------------------------------------------------------------------------
  logic                     p1_v;
  logic [VA_W-1:0]          p1_addr;
  logic [PHASE_BITS-1:0]    new_ph;
  logic                     p2_v;
  logic [PHASE_BITS-1:0]    p2_ph;
  logic [IDX_PW-1:0]        idx_prod;
  logic                     p3_v;
  logic [TI_W-1:0]          p3_idx;
  logic                     p4_v;

  // The phase wraps modulo 2^PHASE_BITS simply by dropping the carry.
  assign new_ph   = vq.phase + vq.step;
  assign idx_prod = IDX_PW'(p2_ph) * IDX_PW'(TABLE_SIZE);

  // Voice RAM port control. During a tick, the read at iss and the write
  // back at iss - 1 always target different voices, so no forwarding.
  always_comb begin
    rd_addr = iss;
    vwe     = 1'b0;
    vwaddr  = p1_addr;
    vwdata  = '0;
    unique case (state)
      ST_CLEAR: begin
        vwaddr = clr_cnt[VA_W-1:0];
        vwe    = (clr_cnt < CLR_W'(VOICE_COUNT));
      end
      ST_IDLE: begin
        rd_addr = note_addr;
      end
      ST_VRMW: begin
        vwe    = 1'b1;
        vwaddr = note_r;
        vwdata = vq;
        unique case (op_r)
          pwo_pkg::OP_NOTE_ON:    vwdata.active = 1'b1;
          pwo_pkg::OP_NOTE_OFF:   vwdata.active = 1'b0;
          pwo_pkg::OP_STEP_WRITE: vwdata.step   = step_r;
          default:                vwdata        = vq;
        endcase
      end
      ST_TICK, ST_DRAIN: begin
        vwe    = p1_v && vq.active;
        vwdata = '{active: 1'b1, step: vq.step, phase: new_ph};
      end
      default: begin
        vwe = 1'b0;
      end
    endcase
  end

  // Wavetable write port: the ramp during the clearing pass, else table writes.
  always_comb begin
    if (state == ST_CLEAR) begin
      twe    = (clr_cnt < CLR_W'(TABLE_SIZE));
      twaddr = clr_cnt[TI_W-1:0];
      twdata = pwo_pkg::SAMPLE_W'(ramp_q - Q_W'(32768));
    end else begin
      twe    = in_xfer && (in_op == pwo_pkg::OP_TABLE_WRITE) && tidx_ok;
      twaddr = tidx_ext[TI_W-1:0];
      twdata = {1'b0, in_tbyte, 7'b0000000};
    end
  end

  always_ff @(posedge clk) begin
    if (vwe) begin
      vmem[vwaddr] <= vwdata;
    end
    vq <= vmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (twe) begin
      tmem[twaddr] <= twdata;
    end
    tq <= tmem[p3_idx];
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    p1_addr <= iss;
    p2_ph   <= new_ph;
    p3_idx  <= idx_prod[PHASE_BITS +: TI_W];
    if (in_xfer) begin
      op_r   <= in_op;
      note_r <= note_addr;
      step_r <= step_masked;
    end
  end

  // Pipeline valid flags; inactive voices drop out after the voice read.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
      p4_v <= 1'b0;
    end else begin
      p1_v <= (state == ST_TICK);
      p2_v <= p1_v && vq.active;
      p3_v <= p2_v;
      p4_v <= p3_v;
    end
  end

  // --------------------------------------------------------------------------
  // Gain scaling and mixing
  // --------------------------------------------------------------------------
  pwo_pkg::acc_ctrl_t              acc_ctrl;
  pwo_pkg::acc_stat_t              acc_stat;
  logic signed [pwo_pkg::SUM_W-1:0] acc_sum;
  logic signed [pwo_pkg::SUM_W-1:0] sum_sat;

  assign acc_ctrl.clear = tick_start;
  assign acc_ctrl.valid = p4_v;

  pwo_scale_acc u_scale_acc (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (acc_ctrl),
    .sample (tq),
    .gain   (gain),
    .sum    (acc_sum),
    .stat   (acc_stat)
  );

  always_comb begin
    priority if (acc_sum > pwo_pkg::SUM_HI) begin
      sum_sat = pwo_pkg::SUM_HI;
    end else if (acc_sum < pwo_pkg::SUM_LO) begin
      sum_sat = pwo_pkg::SUM_LO;
    end else begin
      sum_sat = acc_sum;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic [pwo_pkg::MIX_W-1:0] mix_r;
  logic                      out_load;

  assign out_load = (state == ST_FIN) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      ramp_q    <= '0;
      ramp_r    <= '0;
      iss       <= '0;
      drain_cnt <= '0;
      gain      <= pwo_pkg::GAIN_RESET;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        gain <= cfg_data;
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (ramp_r_sum >= R_W'(TABLE_SIZE)) begin
            ramp_r <= ramp_r_sum - R_W'(TABLE_SIZE);
            ramp_q <= ramp_q + Q_W'(Q_INC + 1);
          end else begin
            ramp_r <= ramp_r_sum;
            ramp_q <= ramp_q + Q_W'(Q_INC);
          end
          if (clr_cnt == CLR_W'(CLR_LEN - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            unique case (in_op)
              pwo_pkg::OP_TICK: begin
                iss   <= '0;
                state <= ST_TICK;
              end
              pwo_pkg::OP_NOTE_ON, pwo_pkg::OP_NOTE_OFF, pwo_pkg::OP_STEP_WRITE: begin
                if (note_ok) begin
                  state <= ST_VRMW;
                end
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_VRMW: begin
          state <= ST_IDLE;
        end
        ST_TICK: begin
          iss <= iss + 1'b1;
          if (iss == VA_W'(VOICE_COUNT - 1)) begin
            drain_cnt <= '0;
            state     <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          drain_cnt <= drain_cnt + 1'b1;
          if (drain_cnt == DRAIN_W'(DRAIN_LEN - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mix_r <= sum_sat[pwo_pkg::MIX_W-1:0];
    end
  end

  assign m_tdata = {{(pwo_pkg::M_TDATA_W - pwo_pkg::MIX_W){1'b0}}, mix_r};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The tick write back never lands on the voice being read in that cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TICK && vwe) |-> (vwaddr != rd_addr))
    else $error("voice RAM write back collides with the tick read");

  // The drain is long enough: nothing is in flight when the sum is taken.
  a_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) |-> !(p1_v || p2_v || p3_v || p4_v || acc_stat.busy))
    else $error("mix sum taken while voices are still in flight");

  // A new sample appears only out of the finishing state.
  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_FIN))
    else $error("output became valid outside the finishing state");

endmodule

`default_nettype wire
